// ===== rtl/pfla_pkg.sv =====
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types and constants of the page free-list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

  localparam int unsigned AddrW   = 48;  // byte address width
  localparam int unsigned FrameW  = 36;  // page frame number width
  localparam int unsigned CountW  = 11;  // pool size and free count width
  localparam int unsigned StatusW = 2;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_NULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  // configuration register indexes
  localparam logic CFG_BASE_FRAME = 1'b0;
  localparam logic CFG_POOL_PAGES = 1'b1;

endpackage

// ===== rtl/pfla_ram.sv =====
// ----------------------------------------------------------------------------
// pfla_ram
// Generic single-port-write, single-port-read RAM, registered read data.
// ----------------------------------------------------------------------------
module pfla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/page_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// page_free_list_allocator
// LIFO free list of fixed-size pages with a bump pointer for untouched pages.
// ----------------------------------------------------------------------------
// Timing: init, free, query and an allocate served from untouched pages pass
//   through the result register only; an allocate popped from the list also
//   waits for the head's link from the link RAM's registered read data.
// Throughput: one beat per cycle while results drain; pops stall the input.
// Reset: control, head, bump pointer, counter and config registers clear; the
//   link RAM is not cleared (entries are only read after being written).
module page_free_list_allocator
  import pfla_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = 1024,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [FrameW-1:0]  cfg_data_i,
  // input beats
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [AddrW-1:0]   page_address_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [AddrW-1:0]   granted_address_o,
  output logic [StatusW-1:0] status_o,
  output logic [CountW-1:0]  free_pages_o
);

  // Page index, counter and working widths all follow from the parameters.
  localparam int unsigned IdxW   = $clog2(MAX_PAGES);
  localparam int unsigned CntW   = $clog2(MAX_PAGES + 1);
  localparam int unsigned SumW   = ((CntW > CountW) ? CntW : CountW) + 1;
  localparam int unsigned Shift  = $clog2(PAGE_BYTES);
  localparam int unsigned FrW    = AddrW - Shift;  // frame width of an address
  localparam int unsigned DiffW  = ((FrW > FrameW) ? FrW : FrameW) + 1;
  localparam int unsigned LinkW  = IdxW + 1;       // {valid, next index}

  typedef enum logic {
    FSM_IDLE,
    FSM_POP
  } fsm_e;

  // configuration
  logic [FrameW-1:0] base_frame_q;
  logic [CountW-1:0] pool_pages_q;

  // list state
  fsm_e            state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic            head_valid_q, head_valid_d;
  logic [CntW-1:0] mark_q, mark_d;      // lowest never-handed-out page
  logic [CntW-1:0] counter_q, counter_d; // entries on the list

  // result register
  logic               out_valid_q, out_valid_d;
  logic [AddrW-1:0]   granted_q, granted_d;
  status_e            status_q, status_d;
  logic [CountW-1:0]  free_q, free_d;

  // link RAM port
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr;
  logic [LinkW-1:0] ram_wdata, ram_rdata;

  // working signals
  logic              accept;
  mode_e             mode;
  logic [SumW-1:0]   pool_sz;
  logic              untouched_avail;
  logic [FrW-1:0]    free_frame;
  logic [DiffW-1:0]  frame_diff;
  logic              free_in_pool;
  logic [IdxW-1:0]  free_idx;
  logic [IdxW-1:0]  grant_idx;
  logic [FrameW:0]  grant_frame;
  logic [AddrW-1:0] grant_addr;
  logic             res_set;     // a result is written this cycle
  logic             res_grant;   // ... and it carries a page
  status_e          res_status;
  logic [SumW-1:0]  untouched, total;

  assign mode   = mode_e'(mode_i);
  // The result register parts the two sides: a new beat is taken while the
  // old result is being drained.
  assign in_ready_o = (state_q == FSM_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Oversized pool setting is clamped to the RAM depth.
  assign pool_sz = (SumW'(pool_pages_q) > SumW'(MAX_PAGES)) ? SumW'(MAX_PAGES)
                                                            : SumW'(pool_pages_q);
  assign untouched_avail = SumW'(mark_q) < pool_sz;

  // Free range check: frame minus base, sign bit set means below the pool.
  assign free_frame   = page_address_i[AddrW-1:Shift];
  assign frame_diff   = DiffW'(free_frame) - DiffW'(base_frame_q);
  assign free_in_pool = !frame_diff[DiffW-1] && (frame_diff < DiffW'(pool_sz));
  assign free_idx     = frame_diff[IdxW-1:0];

  // One adder builds the granted address for both pop and bump allocation.
  assign grant_idx   = (state_q == FSM_POP) ? head_q : mark_q[IdxW-1:0];
  assign grant_frame = (FrameW+1)'(base_frame_q) + (FrameW+1)'(grant_idx);
  assign grant_addr  = AddrW'({grant_frame, {Shift{1'b0}}});

  // ---------------------------------------------------------------------------
  // Next state of the list
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    mark_d       = mark_q;
    counter_d    = counter_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = free_idx;
    ram_wdata    = {head_valid_q, head_q};
    res_set      = 1'b0;
    res_grant    = 1'b0;
    res_status   = STAT_OK;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_INIT: begin
              head_d       = '0;
              head_valid_d = 1'b0;
              mark_d       = '0;
              counter_d    = '0;
              res_set      = 1'b1;
            end
            MODE_ALLOC: begin
              if (head_valid_q) begin
                // fetch the head's link; the result is written from FSM_POP
                ram_re  = 1'b1;
                state_d = FSM_POP;
              end else if (untouched_avail) begin
                mark_d    = mark_q + CntW'(1);
                res_set   = 1'b1;
                res_grant = 1'b1;
              end else begin
                res_set    = 1'b1;
                res_status = STAT_EMPTY;
              end
            end
            MODE_FREE: begin
              res_set = 1'b1;
              if (page_address_i == '0) begin
                res_status = STAT_NULL;
              end else if (!free_in_pool) begin
                res_status = STAT_RANGE;
              end else begin
                ram_we       = 1'b1;
                head_d       = free_idx;
                head_valid_d = 1'b1;
                if (counter_q < CntW'(MAX_PAGES)) begin
                  counter_d = counter_q + CntW'(1);
                end
              end
            end
            MODE_QUERY: begin
              res_set = 1'b1;
            end
            default: begin
              res_set = 1'b1;
            end
          endcase
        end
      end
      FSM_POP: begin
        head_d       = ram_rdata[IdxW-1:0];
        head_valid_d = ram_rdata[IdxW];
        if (counter_q != '0) begin
          counter_d = counter_q - CntW'(1);
        end
        res_set   = 1'b1;
        res_grant = 1'b1;
        state_d   = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register: free count is taken from the state after this beat
  // ---------------------------------------------------------------------------
  always_comb begin
    untouched = (SumW'(mark_d) < pool_sz) ? (pool_sz - SumW'(mark_d)) : '0;
    total     = SumW'(counter_d) + untouched;

    out_valid_d = out_valid_q && !out_ready_i;
    granted_d   = granted_q;
    status_d    = status_q;
    free_d      = free_q;
    if (res_set) begin
      out_valid_d = 1'b1;
      granted_d   = res_grant ? grant_addr : '0;
      status_d    = res_status;
      free_d      = (total > pool_sz) ? pool_sz[CountW-1:0] : total[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      mark_q       <= '0;
      counter_q    <= '0;
      out_valid_q  <= 1'b0;
      base_frame_q <= '0;
      pool_pages_q <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      mark_q       <= mark_d;
      counter_q    <= counter_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE_FRAME: base_frame_q <= cfg_data_i;
          CFG_POOL_PAGES: pool_pages_q <= cfg_data_i[CountW-1:0];
          default:        ;
        endcase
      end
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk_i) begin
    granted_q <= granted_d;
    status_q  <= status_d;
    free_q    <= free_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = granted_q;
  assign status_o          = status_q;
  assign free_pages_o      = free_q;

  // Link RAM: entry = {next valid, next index} of each page on the list.
  // One beat at a time, so a pop read never meets a push write.
  pfla_ram #(
    .WIDTH(LinkW),
    .DEPTH(MAX_PAGES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_POP) |-> !out_valid_q)
    else $error("pop result would overwrite a pending result");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_POP) |-> $past(head_valid_q))
    else $error("pop started on an empty list");

  a_pop_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_POP) |=> (state_q == FSM_IDLE))
    else $error("pop state held longer than one cycle");

  a_ram_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("link RAM read and written in one cycle");

  a_counter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counter_q <= CntW'(MAX_PAGES))
    else $error("free list counter above pool capacity");

endmodule
